@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the interpolator RTL. Every macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PLI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/pwlti_pkg.sv @@
// ----------------------------------------------------------------------------
// pwlti_pkg
// Types, codes and helper functions shared by the interpolator controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package pwlti_pkg;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register map
  localparam int   CFG_IDX_W  = 1;
  localparam int   CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP = 1'b1;
  localparam logic [CFG_DATA_W-1:0] CFG_POINTS_RST = 5'd16;

  // Datapath operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd2;
  localparam logic [OP_W-1:0] OP_RDLAST  = 4'd3;
  localparam logic [OP_W-1:0] OP_CHKLAST = 4'd4;
  localparam logic [OP_W-1:0] OP_PROBE   = 4'd5;
  localparam logic [OP_W-1:0] OP_LEFT    = 4'd6;
  localparam logic [OP_W-1:0] OP_PREP    = 4'd7;
  localparam logic [OP_W-1:0] OP_MAG     = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL0    = 4'd9;
  localparam logic [OP_W-1:0] OP_MUL1    = 4'd10;
  localparam logic [OP_W-1:0] OP_DIVINIT = 4'd11;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd12;
  localparam logic [OP_W-1:0] OP_FINISH  = 4'd13;

  // Divider: quotient is capped at 2^DIV_BITS, two bits retired per cycle
  localparam int DIV_BITS       = 40;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES     = DIV_BITS / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  // Result range in the widened sum
  localparam logic signed [41:0] RES_MAX = 42'sh000_7FFF_FFFF;
  localparam logic signed [41:0] RES_MIN = 42'sh3FF_8000_0000;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic found;      // segment search finished
    logic zero;       // segment has zero width
    logic ovf;        // quotient reaches the cap
    logic div_last;   // final divider cycle
    logic out_valid;  // output register holds a result
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        qb;
  } div_res_t;

  // Magnitude of a 33-bit signed value
  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m;
  endfunction

  // One restoring division step; rem is always below d
  function automatic div_res_t div_step(input logic [31:0] rem, input logic nb,
                                        input logic [32:0] d);
    div_res_t   r;
    logic [32:0] t;
    t = {rem, nb};
    if (t >= d) begin
      r.rem = 32'(t - d);
      r.qb  = 1'b1;
    end else begin
      r.rem = t[31:0];
      r.qb  = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/piecewise_linear_table_interp_core.sv @@
// Piecewise-linear table interpolator, signed Q16.16. A write item (kind 0)
// stores one x/y breakpoint; a query (kind 1) gives one result. In a query
// the segment search walks 0 to points_in_use - 2 breakpoints, one memory
// read per cycle, and the radix-4 divider then forms the 40-bit quotient;
// a query that lands on a zero-width segment or whose quotient reaches the
// cap skips the divider. One item is in work at a time; the finished
// result waits in an output register so the next item can be taken while
// it is unclaimed.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// Top level: joins the sequencer and the datapath and presents the input,
// result and configuration ports.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core #(
  parameter int MAX_POINTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pwlti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwlti_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [3:0]                        in_point_index,
  input  logic signed [31:0]                in_point_x,
  input  logic signed [31:0]                in_point_y,
  input  logic signed [31:0]                in_sample_x,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_value_y,
  output logic [3:0]                        out_segment_used,
  output logic                              out_zero_width_fault,
  output logic                              out_saturated
);
  import pwlti_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // Sequencer
  pwlti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath
  pwlti_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_point_index       (in_point_index),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_sample_x          (in_sample_x),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_value_y          (out_value_y),
    .out_segment_used     (out_segment_used),
    .out_zero_width_fault (out_zero_width_fault),
    .out_saturated        (out_saturated)
  );

endmodule

@@ hw/rtl/pwlti_ctrl.sv @@
// ----------------------------------------------------------------------------
// pwlti_ctrl
// Sequencer for the interpolator: accepts items, steps the datapath through
// search, fetch, multiply and divide, and hands the result to the output
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwlti_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  input  logic               out_ready,
  input  pwlti_pkg::dp_stat_t st,
  output pwlti_pkg::dp_cmd_t  cmd
);
  import pwlti_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RDLAST  = 4'd1;
  localparam logic [3:0] S_CHKLAST = 4'd2;
  localparam logic [3:0] S_PROBE   = 4'd3;
  localparam logic [3:0] S_LEFT    = 4'd4;
  localparam logic [3:0] S_PREP    = 4'd5;
  localparam logic [3:0] S_MAG     = 4'd6;
  localparam logic [3:0] S_MUL0    = 4'd7;
  localparam logic [3:0] S_MUL1    = 4'd8;
  localparam logic [3:0] S_DIVINIT = 4'd9;
  localparam logic [3:0] S_DIV     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_QUERY) begin
            cmd.op    = OP_LOAD;
            state_nxt = S_RDLAST;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_RDLAST: begin
        cmd.op    = OP_RDLAST;
        state_nxt = S_CHKLAST;
      end
      S_CHKLAST: begin
        cmd.op    = OP_CHKLAST;
        state_nxt = st.found ? S_LEFT : S_PROBE;
      end
      S_PROBE: begin
        cmd.op    = OP_PROBE;
        state_nxt = st.found ? S_LEFT : S_PROBE;
      end
      S_LEFT: begin
        cmd.op    = OP_LEFT;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = st.zero ? S_DONE : S_MAG;
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.op    = OP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = OP_MUL1;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.op    = OP_DIVINIT;
        state_nxt = st.ovf ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (st.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!st.out_valid || out_ready) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PLI_ASSERT_NEXT(a_finish_fills_out, cmd.op == OP_FINISH, st.out_valid, "result not registered after finish")
  `PLI_ASSERT_IMPL(a_ready_no_work, in_ready, (cmd.op == OP_NONE) || (cmd.op == OP_WRITE) || (cmd.op == OP_LOAD), "work issued while accepting")

endmodule

@@ hw/rtl/pwlti_dp.sv @@
// ----------------------------------------------------------------------------
// pwlti_dp
// Interpolator datapath: configuration registers, breakpoint memories,
// segment search, clamp, split multiplier, radix-4 divider and the output
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwlti_dp #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pwlti_pkg::dp_cmd_t                   cmd,
  output pwlti_pkg::dp_stat_t                  st,
  input  logic                                 cfg_wr_en,
  input  logic [pwlti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwlti_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [3:0]                           in_point_index,
  input  logic signed [31:0]                   in_point_x,
  input  logic signed [31:0]                   in_point_y,
  input  logic signed [31:0]                   in_sample_x,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [31:0]                   out_value_y,
  output logic [3:0]                           out_segment_used,
  output logic                                 out_zero_width_fault,
  output logic                                 out_saturated
);
  import pwlti_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;

  // Configuration
  logic [CFG_DATA_W-1:0] points_r;
  logic                  extrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= CFG_POINTS_RST;
      extrap_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POINTS: points_r <= cfg_wdata;
        CFG_EXTRAP: extrap_r <= cfg_wdata[0];
        default:    points_r <= points_r;
      endcase
    end
  end

  // Breakpoint memories
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic        slot_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic signed [31:0] rd_x_r, rd_y_r;

  assign slot_ok = (32'(in_point_index) < 32'(MAX_POINTS));
  assign wr_addr = AW'(in_point_index);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && slot_ok) begin
      mem_x[wr_addr] <= in_point_x;
      mem_y[wr_addr] <= in_point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= $signed(mem_x[rd_addr]);
      rd_y_r <= $signed(mem_y[rd_addr]);
    end
  end

  // Query state
  logic signed [31:0] x_r;
  logic [AW-1:0]      last_r;
  logic [AW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      pts_c, n_c;

  // Clamp the used point count to [2, MAX_POINTS]
  always_comb begin
    pts_c = CW'(points_r);
    if (pts_c < CW'(2)) begin
      n_c = CW'(2);
    end else if (pts_c > CW'(MAX_POINTS)) begin
      n_c = CW'(MAX_POINTS);
    end else begin
      n_c = pts_c;
    end
  end

  // Search control and read address
  logic          ge_last, cont;
  logic [AW-1:0] i_step;
  logic          more;
  logic          found_c;

  always_comb begin
    ge_last = (x_r >= rd_x_r) || (last_r == '0);
    cont    = (x_r > rd_x_r);
    i_step  = cont ? AW'(i_r + 1'b1) : i_r;
    more    = cont && (i_step < last_r);
    rd_en   = 1'b0;
    rd_addr = i_r;
    i_nxt   = i_r;
    found_c = 1'b0;
    case (cmd.op)
      OP_RDLAST: begin
        rd_en   = 1'b1;
        rd_addr = last_r;
      end
      OP_CHKLAST: begin
        rd_en   = 1'b1;
        found_c = ge_last;
        i_nxt   = ge_last ? last_r : '0;
        rd_addr = ge_last ? last_r : AW'(1);
      end
      OP_PROBE: begin
        rd_en   = 1'b1;
        found_c = !more;
        i_nxt   = i_step;
        rd_addr = more ? AW'(i_step + 1'b1) : i_step;
      end
      OP_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = AW'(i_r + 1'b1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign st.found = found_c;

  // Clamp and differences, from left (registered) and right (read data)
  logic signed [31:0] xl_r, yl_r;
  logic signed [31:0] yr1_c, yb_c;
  logic signed [32:0] den_c, dx_c, dy_c;

  always_comb begin
    yr1_c = (!extrap_r && (x_r < xl_r)) ? yl_r : rd_y_r;
    yb_c  = (!extrap_r && (x_r > rd_x_r)) ? yr1_c : yl_r;
    den_c = $signed({rd_x_r[31], rd_x_r}) - $signed({xl_r[31], xl_r});
    dx_c  = $signed({x_r[31], x_r}) - $signed({xl_r[31], xl_r});
    dy_c  = $signed({yr1_c[31], yr1_c}) - $signed({yb_c[31], yb_c});
  end

  assign st.zero = (den_c == '0);

  logic signed [31:0] yb_r;
  logic               zero_r;
  logic signed [32:0] den_r, dx_r, dy_r;
  logic [32:0]        a_r, b_r, d_r;
  logic               neg_r;
  logic [49:0]        p0_r;
  logic [48:0]        p1_r;

  // Product recombination and overflow check against the quotient cap
  logic [64:0] prod_c;
  assign prod_c = 65'(p0_r) + 65'({p1_r, 17'b0});
  assign st.ovf = (33'(prod_c[64:DIV_BITS]) >= d_r);

  // Divider: two restoring steps per cycle
  logic [31:0]          rem_r, rem_c;
  logic [DIV_BITS-1:0]  dq_r, dq_c;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 ovf_r;
  div_res_t             ds;

  always_comb begin
    rem_c = rem_r;
    dq_c  = dq_r;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      ds    = div_step(rem_c, dq_c[DIV_BITS-1], d_r);
      rem_c = ds.rem;
      dq_c  = {dq_c[DIV_BITS-2:0], ds.qb};
    end
  end

  assign st.div_last = (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));

  // Final sum and saturation
  logic [DIV_BITS:0]  q_c;
  logic signed [41:0] yb_e, q_e, res_c;
  logic signed [31:0] val_c;
  logic               sat_c;

  always_comb begin
    q_c   = ovf_r ? {1'b1, {DIV_BITS{1'b0}}} : {1'b0, dq_r};
    yb_e  = {{10{yb_r[31]}}, yb_r};
    q_e   = $signed(42'(q_c));
    res_c = neg_r ? (yb_e - q_e) : (yb_e + q_e);
    sat_c = 1'b0;
    if (zero_r) begin
      val_c = yb_r;
    end else if (res_c > RES_MAX) begin
      val_c = RES_MAX[31:0];
      sat_c = 1'b1;
    end else if (res_c < RES_MIN) begin
      val_c = RES_MIN[31:0];
      sat_c = 1'b1;
    end else begin
      val_c = res_c[31:0];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    case (cmd.op)
      OP_LOAD: begin
        x_r    <= in_sample_x;
        last_r <= AW'(n_c - CW'(2));
      end
      OP_LEFT: begin
        xl_r <= rd_x_r;
        yl_r <= rd_y_r;
      end
      OP_PREP: begin
        yb_r   <= yb_c;
        zero_r <= st.zero;
        den_r  <= den_c;
        dx_r   <= dx_c;
        dy_r   <= dy_c;
      end
      OP_MAG: begin
        a_r   <= abs33(dy_r);
        b_r   <= abs33(dx_r);
        d_r   <= abs33(den_r);
        neg_r <= (dy_r[32] ^ dx_r[32]) ^ den_r[32];
      end
      OP_MUL0: begin
        p0_r <= 50'(a_r) * 50'(b_r[16:0]);
      end
      OP_MUL1: begin
        p1_r <= 49'(a_r) * 49'(b_r[32:17]);
      end
      OP_DIVINIT: begin
        ovf_r <= st.ovf;
        rem_r <= 32'(prod_c[64:DIV_BITS]);
        dq_r  <= prod_c[DIV_BITS-1:0];
        cnt_r <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_c;
        dq_r  <= dq_c;
        cnt_r <= DIV_CNT_W'(cnt_r + 1'b1);
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // Output register
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [3:0]         out_seg_r;
  logic               out_fault_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_value_r <= val_c;
      out_seg_r   <= 4'(i_r);
      out_fault_r <= zero_r;
      out_sat_r   <= sat_c;
    end
  end

  assign st.out_valid         = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_value_y          = out_value_r;
  assign out_segment_used     = out_seg_r;
  assign out_zero_width_fault = out_fault_r;
  assign out_saturated        = out_sat_r;

  `PLI_ASSERT_IMPL(a_probe_in_range, cmd.op == OP_PROBE, i_r < last_r, "probe beyond last segment")
  `PLI_ASSERT_IMPL(a_rem_below_div, cmd.op == OP_DIV, 33'(rem_r) < d_r, "divider remainder not below divisor")
  `PLI_ASSERT_IMPL(a_fault_no_sat, out_valid_r, !(out_fault_r && out_sat_r), "zero-width result flagged saturated")

endmodule

@@ tb/piecewise_linear_table_interp_core_tb.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core_tb
// Self-checking bench for the breakpoint-table interpolator. A short table of
// directed transfers covers the range extremes, zero-width segments, result
// saturation, clamped point counts and an unordered table. Random phases then
// change the settings, reload the table and send biased queries. Every result
// is checked against a predictor kept in the bench or a typed-in directed result,
// with random gaps on the input channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core_tb;
  import pwlti_pkg::*;

  localparam int NUM_SLOTS     = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 20;

  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic [65:0]        QUO_CAP = 66'd1 << 40;

  typedef struct packed {
    logic signed [31:0] value_y;
    logic [3:0]         segment;
    logic               zero_width;
    logic               saturated;
  } interp_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CONFIG} row_act_t;

  // x is the breakpoint x for a write and the sample for a query
  typedef struct {
    row_act_t           act;
    logic [3:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [4:0]         points;
    logic               extrap;
    logic               known;
    interp_result_t     result;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_kind;
  logic [3:0]               in_point_index;
  logic signed [31:0]       in_point_x;
  logic signed [31:0]       in_point_y;
  logic signed [31:0]       in_sample_x;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [31:0]       out_value_y;
  logic [3:0]               out_segment_used;
  logic                     out_zero_width_fault;
  logic                     out_saturated;

  // Predictor copy of the table and the settings
  logic signed [31:0] bp_x [NUM_SLOTS];
  logic signed [31:0] bp_y [NUM_SLOTS];
  logic [4:0]         pred_points = 5'd16;
  logic               pred_extrap = 1'b0;
  interp_result_t     expected_results [$];

  int mismatches      = 0;
  int writes_sent     = 0;
  int queries_sent    = 0;
  int results_checked = 0;
  int zero_width_seen = 0;
  int saturated_seen  = 0;
  int settings_used   = 0;
  int send_calm       = 0;
  int recv_calm       = 0;
  int idle_cycles     = 0;

  // Directed rows: results typed in where they follow at a glance
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    // count below two is used as two
    '{ROW_CONFIG, 4'd0,  32'sd0,         32'sd0,         5'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE,  4'd0,  Q_MIN,          Q_MAX,          5'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE,  4'd1,  Q_MAX,          Q_MIN,          5'd0, 1'b0, 1'b0, '0},
    '{ROW_QUERY,  4'd0,  Q_MIN,          32'sd0,         5'd0, 1'b0, 1'b1,
      '{Q_MAX, 4'd0, 1'b0, 1'b0}},
    '{ROW_QUERY,  4'd0,  Q_MAX,          32'sd0,         5'd0, 1'b0, 1'b1,
      '{Q_MIN, 4'd0, 1'b0, 1'b0}},
    '{ROW_QUERY,  4'd0,  32'sd0,         32'sd0,         5'd0, 1'b0, 1'b0, '0},
    // zero-width segment, inside and clamped past the right end
    '{ROW_WRITE,  4'd1,  Q_MIN,          32'sh1234_5678, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_QUERY,  4'd0,  Q_MIN,          32'sd0,         5'd0, 1'b0, 1'b1,
      '{Q_MAX, 4'd0, 1'b1, 1'b0}},
    '{ROW_QUERY,  4'd0,  Q_MAX,          32'sd0,         5'd0, 1'b0, 1'b1,
      '{32'sh1234_5678, 4'd0, 1'b1, 1'b0}},
    // steep line with extrapolation: quotient hits the cap, result saturates
    '{ROW_CONFIG, 4'd0,  32'sd0,         32'sd0,         5'd1, 1'b1, 1'b0, '0},
    '{ROW_WRITE,  4'd0,  32'sd0,         32'sd0,         5'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE,  4'd1,  32'sd1,         Q_MAX,          5'd0, 1'b0, 1'b0, '0},
    '{ROW_QUERY,  4'd0,  Q_MAX,          32'sd0,         5'd0, 1'b0, 1'b1,
      '{Q_MAX, 4'd0, 1'b0, 1'b1}},
    '{ROW_QUERY,  4'd0,  Q_MIN,          32'sd0,         5'd0, 1'b0, 1'b1,
      '{Q_MIN, 4'd0, 1'b0, 1'b1}},
    '{ROW_QUERY,  4'd0,  32'sh0000_8000, 32'sd0,         5'd0, 1'b0, 1'b0, '0},
    // unordered pair: negative segment width
    '{ROW_WRITE,  4'd0,  32'sh0003_0000, 32'sh0001_0000, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE,  4'd1,  32'sh0001_0000, 32'sh0005_0000, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_QUERY,  4'd0,  32'sh0002_0000, 32'sd0,         5'd0, 1'b0, 1'b0, '0},
    '{ROW_QUERY,  4'd0,  32'sh0004_0000, 32'sd0,         5'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE,  4'd15, Q_MAX,          Q_MAX,          5'd0, 1'b0, 1'b0, '0}
  };

  piecewise_linear_table_interp_core #(
    .MAX_POINTS (NUM_SLOTS)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_point_index       (in_point_index),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_sample_x          (in_sample_x),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_value_y          (out_value_y),
    .out_segment_used     (out_segment_used),
    .out_zero_width_fault (out_zero_width_fault),
    .out_saturated        (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Point count after clamping to the legal span
  function automatic int used_points();
    if (pred_points < 2) return 2;
    if (pred_points > NUM_SLOTS) return NUM_SLOTS;
    return int'(pred_points);
  endfunction

  // Segment search and interpolation on the predictor's table
  function automatic interp_result_t interpolate(input logic signed [31:0] sx);
    interp_result_t r;
    int             n;
    int             seg;
    longint         x, xl, yl, xr, yr, dy, dxq, den, sum;
    logic [32:0]    mag_dy, mag_dx, mag_den;
    logic [65:0]    quo;
    logic           neg;
    n = used_points();
    if (sx >= bp_x[n-2]) begin
      seg = n - 2;
    end else begin
      seg = 0;
      while (seg < n - 2 && sx > bp_x[seg+1]) seg++;
    end
    x  = longint'(sx);
    xl = longint'(bp_x[seg]);
    yl = longint'(bp_y[seg]);
    xr = longint'(bp_x[seg+1]);
    yr = longint'(bp_y[seg+1]);
    // clamp to the end values outside the segment
    if (!pred_extrap) begin
      if (x < xl) yr = yl;
      if (x > xr) yl = yr;
    end
    den = xr - xl;
    r.segment    = 4'(seg);
    r.zero_width = (den == 0);
    r.saturated  = 1'b0;
    if (den == 0) begin
      sum = yl;
    end else begin
      dy      = yr - yl;
      dxq     = x - xl;
      neg     = ((dy < 0) != (dxq < 0)) != (den < 0);
      mag_dy  = 33'((dy < 0) ? -dy : dy);
      mag_dx  = 33'((dxq < 0) ? -dxq : dxq);
      mag_den = 33'((den < 0) ? -den : den);
      quo     = (66'(mag_dy) * 66'(mag_dx)) / 66'(mag_den);
      if (quo > QUO_CAP) quo = QUO_CAP;
      sum = neg ? yl - longint'(quo[63:0]) : yl + longint'(quo[63:0]);
      if (sum > Q_MAX) begin
        sum         = Q_MAX;
        r.saturated = 1'b1;
      end else if (sum < Q_MIN) begin
        sum         = Q_MIN;
        r.saturated = 1'b1;
      end
    end
    r.value_y = 32'(sum);
    return r;
  endfunction

  // Idle length per transfer: sometimes a calm stretch with no idling at all
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("MISMATCH @%0t: %s expected %h got %h", $time, field, want, got);
  endtask

  // One input transfer; fields the kind does not use carry random values
  task automatic send_item(input logic kind, input logic [3:0] slot,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] sx, input logic known = 1'b0,
                           input interp_result_t known_result = '0);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind        <= kind;
    in_point_index <= (kind == KIND_WRITE) ? slot : 4'($urandom);
    in_point_x     <= (kind == KIND_WRITE) ? px : 32'($urandom);
    in_point_y     <= (kind == KIND_WRITE) ? py : 32'($urandom);
    in_sample_x    <= (kind == KIND_QUERY) ? sx : 32'($urandom);
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_QUERY) begin
      expected_results.push_back(known ? known_result : interpolate(sx));
      queries_sent++;
    end else begin
      bp_x[slot] = px;
      bp_y[slot] = py;
      writes_sent++;
    end
  endtask

  // Let every result drain, then give a trailing write time to finish
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers in back-to-back write cycles
  task automatic load_settings(input logic [4:0] points, input logic extrap);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_POINTS;
    cfg_wdata <= points;
    @(posedge clk);
    cfg_index <= CFG_EXTRAP;
    cfg_wdata <= CFG_DATA_W'(extrap);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pred_points  = points;
    pred_extrap  = extrap;
    settings_used++;
  endtask

  // Result side: random stalls, every transfer checked against the oldest entry
  initial begin : result_sink
    interp_result_t want;
    int             gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, value_y", 32'd0, out_value_y);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        zero_width_seen += want.zero_width;
        saturated_seen  += want.saturated;
        if (out_value_y !== want.value_y)
          report_mismatch("value_y", want.value_y, out_value_y);
        if (out_segment_used !== want.segment)
          report_mismatch("segment_used", 32'(want.segment), 32'(out_segment_used));
        if (out_zero_width_fault !== want.zero_width)
          report_mismatch("zero_width_fault", 32'(want.zero_width),
                          32'(out_zero_width_fault));
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", 32'(want.saturated), 32'(out_saturated));
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("piecewise_linear_table_interp_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                 phase;
    int                 random_items;
    int                 k;
    int                 pick;
    int                 mode;
    int                 start;
    int                 budget;
    int                 y_val;
    int                 table_x [$];
    logic signed [31:0] base;
    logic signed [31:0] sx;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_POINTS;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_point_index = '0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_sample_x    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      case (directed_rows[r].act)
        ROW_CONFIG: begin
          wait_for_quiet();
          load_settings(directed_rows[r].points, directed_rows[r].extrap);
        end
        ROW_WRITE: begin
          send_item(KIND_WRITE, directed_rows[r].slot, directed_rows[r].x,
                    directed_rows[r].y, 32'sd0);
        end
        default: begin
          send_item(KIND_QUERY, 4'd0, 32'sd0, 32'sd0, directed_rows[r].x,
                    directed_rows[r].known, directed_rows[r].result);
        end
      endcase
    end

    // Random phases: new settings, often a fresh table, then biased queries
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_for_quiet();
      case (phase)
        0: load_settings(5'd16, 1'b0);
        1: load_settings(5'd2, 1'b1);
        2: load_settings(5'd31, 1'b1);
        default: begin
          if ($urandom_range(0, 9) == 0)
            load_settings(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
          else
            load_settings(5'($urandom_range(2, 16)), 1'($urandom_range(0, 1)));
        end
      endcase

      // full table reload; the first phase must fill every slot
      if (phase == 0 || $urandom_range(0, 9) < 6) begin
        mode = $urandom_range(0, 3);
        base = $urandom;
        table_x.delete();
        for (k = 0; k < NUM_SLOTS; k++) begin
          case (mode)
            0: table_x.push_back(int'($urandom));
            1: table_x.push_back(int'(base >>> 1) + int'($urandom_range(0, 32'h000F_FFFF)));
            2: table_x.push_back(int'(base >>> 5) + k * 32'sh0001_0000);
            default: table_x.push_back(int'($urandom));   // left unordered
          endcase
        end
        if (mode != 3) table_x.sort();
        if ($urandom_range(0, 4) == 0) begin
          pick = $urandom_range(0, NUM_SLOTS - 2);
          table_x[pick + 1] = table_x[pick];
        end
        start = $urandom_range(0, NUM_SLOTS - 1);
        for (k = 0; k < NUM_SLOTS; k++) begin
          pick = (start + k) % NUM_SLOTS;
          if ($urandom_range(0, 3) == 0)
            y_val = int'($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
          else
            y_val = int'($urandom);
          send_item(KIND_WRITE, 4'(pick), table_x[pick], y_val, 32'sd0);
          random_items++;
        end
      end

      // queries near breakpoints, at the extremes and anywhere; a few stray writes
      budget = $urandom_range(30, 45);
      for (k = 0; k < budget; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_item(KIND_WRITE, 4'($urandom), 32'($urandom), 32'($urandom), 32'sd0);
        end else begin
          pick = $urandom_range(0, used_points() - 1);
          case ($urandom_range(0, 9))
            0, 1, 2: sx = bp_x[pick];
            3, 4:    sx = bp_x[pick] + int'($urandom_range(0, 32'h0003_FFFF))
                          - 32'sh0002_0000;
            5:       sx = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            default: sx = $urandom;
          endcase
          send_item(KIND_QUERY, 4'd0, 32'sd0, 32'sd0, sx);
        end
        random_items++;
      end
      phase++;
    end

    wait_for_quiet();
    $display("Run covered %0d breakpoint writes and %0d queries over %0d settings.",
             writes_sent, queries_sent, settings_used);
    $display("Checked %0d results: %0d zero-width, %0d saturated; %0d mismatches.",
             results_checked, zero_width_seen, saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("piecewise_linear_table_interp_core test passed");
    end else begin
      $display("piecewise_linear_table_interp_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pwlti_pkg.sv
hw/rtl/pwlti_ctrl.sv
hw/rtl/pwlti_dp.sv
hw/rtl/piecewise_linear_table_interp_core.sv
tb/piecewise_linear_table_interp_core_tb.sv
